// ===== hdl/erbr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erbr_pkg
// Shared types, widths and status codes of the equal radius biarc radius block.
// ----------------------------------------------------------------------------
package erbr_pkg;

    // datapath widths
    localparam int K_W        = 104;  // discriminant P^2 - Q*S
    localparam int ROOT_W     = 52;   // floor(sqrt(K))
    localparam int REM_W      = 54;   // square root partial remainder
    localparam int P_W        = 53;   // P, signed
    localparam int Q_W        = 39;   // Q, signed
    localparam int QM_W       = 38;   // |Q|
    localparam int NM_W       = 53;   // |P - root|
    localparam int QUO_W      = 33;   // quotient bits kept
    localparam int SQRT_CELLS = ROOT_W;
    localparam int DIV_CELLS  = QUO_W;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NEG_DISC = 2'd1,
        ST_ZERO_DEN = 2'd2,
        ST_SAT      = 2'd3
    } status_e;

    typedef struct packed {
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [31:0] end_x;
        logic [31:0] end_y;
        logic [17:0] dir_a_x;
        logic [17:0] dir_a_y;
        logic [17:0] dir_b_x;
        logic [17:0] dir_b_y;
    } query_t;

    typedef struct packed {
        logic [31:0] radius;
        logic [1:0]  status;
    } result_t;

    // beat moving through the square root cells
    typedef struct packed {
        logic [K_W-1:0]    kr;    // radicand, consumed two bits per cell
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [P_W-1:0]    p;
        logic [Q_W-1:0]    q;
        status_e           st;
    } sqrt_t;

    // beat moving through the divider cells
    typedef struct packed {
        logic [QM_W-1:0]  rem;
        logic [QM_W-1:0]  qm;
        logic [QUO_W-1:0] num;    // low dividend bits, consumed one per cell
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             over;
        status_e          st;
    } div_t;

endpackage
`default_nettype wire

// ===== hdl/equal_radius_biarc_radius.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// equal_radius_biarc_radius
// Common radius of two equal tangent arcs joining two points with normals.
// ----------------------------------------------------------------------------
// The block takes one query beat per cycle unless a stalled output has filled
// the chain, and returns one result beat per query, in order, through six
// front stages (differences, products, P/Q/S, split products, P^2 and |Q|*S,
// K), 52 square root cells giving one root bit each, one stage forming
// P - root and |Q|, 33 divider cells giving one quotient bit each, and the
// output register. Every stage holds its beat independently, so a stalled
// output fills upstream bubbles and queries are taken until the chain is full.
// ----------------------------------------------------------------------------
module equal_radius_biarc_radius (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             query_valid,
    output logic                  query_ready,
    input  wire erbr_pkg::query_t query,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output erbr_pkg::result_t     result
);
    import erbr_pkg::*;

    sqrt_t              sq_link  [SQRT_CELLS+1];
    logic [SQRT_CELLS:0] sq_valid, sq_ready;
    div_t               dv_link  [DIV_CELLS+1];
    logic [DIV_CELLS:0] dv_valid, dv_ready;

    logic               d0_valid_reg;
    div_t               d0_next;
    logic               out_valid_reg;
    result_t            out_reg, out_next;
    logic               out_rdy;

    logic signed [NM_W:0] n;
    logic [NM_W:0]      nm_full;
    logic [NM_W-1:0]    nm;
    logic [Q_W-1:0]     qm_full;
    logic [QUO_W-1:0]   m;
    logic               sat_pos, sat_neg;
    div_t               last;

    // front end
    erbr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (query_valid),
        .up_ready (query_ready),
        .up       (query),
        .dn_valid (sq_valid[0]),
        .dn_ready (sq_ready[0]),
        .dn       (sq_link[0])
    );

    // square root chain
    for (genvar i = 0; i < SQRT_CELLS; i++)
    begin : g_sqrt
        erbr_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (sq_valid[i]),
            .up_ready (sq_ready[i]),
            .up       (sq_link[i]),
            .dn_valid (sq_valid[i+1]),
            .dn_ready (sq_ready[i+1]),
            .dn       (sq_link[i+1])
        );
    end

    // numerator and divisor setup
    always_comb
    begin
        n       = $signed({sq_link[SQRT_CELLS].p[P_W-1], sq_link[SQRT_CELLS].p})
                - $signed({2'b00, sq_link[SQRT_CELLS].root});
        nm_full = n[NM_W] ? (NM_W+1)'(-n) : (NM_W+1)'(n);
        nm      = nm_full[NM_W-1:0];
        qm_full = sq_link[SQRT_CELLS].q[Q_W-1] ? Q_W'(-sq_link[SQRT_CELLS].q)
                                                : sq_link[SQRT_CELLS].q;
        d0_next.qm   = qm_full[QM_W-1:0];
        d0_next.rem  = QM_W'(nm[NM_W-1:17]);
        d0_next.over = ({2'b00, nm[NM_W-1:17]} >= qm_full[QM_W-1:0]);
        d0_next.num  = {nm[16:0], 16'h0000};
        d0_next.quo  = '0;
        d0_next.neg  = n[NM_W] ^ sq_link[SQRT_CELLS].q[Q_W-1];
        d0_next.st   = sq_link[SQRT_CELLS].st;
    end

    assign sq_ready[SQRT_CELLS] = ~d0_valid_reg | dv_ready[0];
    assign dv_valid[0]          = d0_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d0_valid_reg <= 1'b0;
        end
        else if (sq_ready[SQRT_CELLS])
        begin
            d0_valid_reg <= sq_valid[SQRT_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_ready[SQRT_CELLS] && sq_valid[SQRT_CELLS])
        begin
            dv_link[0] <= d0_next;
        end
    end

    // divider chain
    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_div
        erbr_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (dv_valid[i]),
            .up_ready (dv_ready[i]),
            .up       (dv_link[i]),
            .dn_valid (dv_valid[i+1]),
            .dn_ready (dv_ready[i+1]),
            .dn       (dv_link[i+1])
        );
    end

    // sign, saturation and status
    always_comb
    begin
        last    = dv_link[DIV_CELLS];
        m       = last.quo;
        sat_pos = last.over | m[32] | m[31];
        sat_neg = last.over | m[32] | (m[31] & (|m[30:0]));
        if (last.st != ST_OK)
        begin
            out_next.radius = '0;
            out_next.status = last.st;
        end
        else if (last.neg)
        begin
            out_next.radius = sat_neg ? 32'h8000_0000 : 32'(-m[31:0]);
            out_next.status = sat_neg ? ST_SAT : ST_OK;
        end
        else
        begin
            out_next.radius = sat_pos ? 32'h7FFF_FFFF : m[31:0];
            out_next.status = sat_pos ? ST_SAT : ST_OK;
        end
    end

    assign out_rdy             = ~out_valid_reg | result_ready;
    assign dv_ready[DIV_CELLS] = out_rdy;
    assign result_valid        = out_valid_reg;
    assign result              = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_rdy)
        begin
            out_valid_reg <= dv_valid[DIV_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy && dv_valid[DIV_CELLS])
        begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/erbr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erbr_front
// Six stage front end: differences, products, P/Q/S, split products, P^2 and |Q|*S, and K.
// ----------------------------------------------------------------------------
module erbr_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             up_valid,
    output logic                  up_ready,
    input  wire erbr_pkg::query_t up,
    output logic                  dn_valid,
    input  wire logic             dn_ready,
    output erbr_pkg::sqrt_t       dn
);
    import erbr_pkg::*;

    localparam int NST = 6;

    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;
    logic [NST-1:0] ld;

    // stage 1: differences
    logic signed [32:0] dx_reg, dy_reg, dx_next, dy_next;
    logic signed [18:0] ex_reg, ey_reg, ex_next, ey_next;
    // stage 2: products
    logic signed [51:0] pex_reg, pey_reg, pex_next, pey_next;
    logic [36:0]        exsq_reg, eysq_reg, exsq_next, eysq_next;
    logic [63:0]        dxsq_reg, dysq_reg, dxsq_next, dysq_next;
    // stage 3: P, Q, S
    logic [P_W-1:0]     p3_reg, p3_next;
    logic [Q_W-1:0]     q3_reg, q3_next;
    logic [65:0]        s3_reg, s3_next;
    logic               qz3_reg, qz3_next;
    // stage 4: partial products
    logic [51:0]        phh_reg, phl_reg, pll_reg, phh_next, phl_next, pll_next;
    logic [40:0]        qs_pp_reg [2][3];
    logic [40:0]        qs_pp_next[2][3];
    logic [P_W-1:0]     p4_reg;
    logic [Q_W-1:0]     q4_reg;
    logic               qz4_reg;
    // stage 5: P^2 and |Q|*S
    logic [K_W-1:0]     p2_reg, qs_reg, p2_next, qs_next;
    logic [P_W-1:0]     p5_reg;
    logic [Q_W-1:0]     q5_reg;
    logic               qz5_reg;
    // stage 6: K
    sqrt_t              out_reg, out_next;

    logic [32:0]        dxm, dym;
    logic [18:0]        exm, eym;
    logic [P_W-1:0]     pm_full;
    logic [51:0]        pm;
    logic [Q_W-1:0]     qm_full;
    logic [QM_W-1:0]    qm;
    logic [K_W:0]       diff;
    logic               q_pos;

    // per stage ready: a stage takes a beat when empty or draining
    always_comb
    begin
        rdy[NST] = dn_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            rdy[i] = ~v_reg[i] | rdy[i+1];
        end
        ld[0] = rdy[0] & up_valid;
        for (int i = 1; i < NST; i++)
        begin
            ld[i] = rdy[i] & v_reg[i-1];
        end
    end

    assign up_ready = rdy[0];
    assign dn_valid = v_reg[NST-1];
    assign dn       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= up_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // stage 1 logic
    always_comb
    begin
        dx_next = $signed({up.start_x[31], up.start_x}) - $signed({up.end_x[31], up.end_x});
        dy_next = $signed({up.start_y[31], up.start_y}) - $signed({up.end_y[31], up.end_y});
        ex_next = $signed({up.dir_a_x[17], up.dir_a_x}) - $signed({up.dir_b_x[17], up.dir_b_x});
        ey_next = $signed({up.dir_a_y[17], up.dir_a_y}) - $signed({up.dir_b_y[17], up.dir_b_y});
    end

    // stage 2 logic: one multiplier per path
    always_comb
    begin
        dxm       = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        dym       = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
        exm       = ex_reg[18] ? 19'(-ex_reg) : 19'(ex_reg);
        eym       = ey_reg[18] ? 19'(-ey_reg) : 19'(ey_reg);
        pex_next  = 52'(dx_reg * ex_reg);
        pey_next  = 52'(dy_reg * ey_reg);
        exsq_next = 37'(exm * exm);
        eysq_next = 37'(eym * eym);
        dxsq_next = dxm[31:0] * dxm[31:0];
        dysq_next = dym[31:0] * dym[31:0];
    end

    // stage 3 logic
    always_comb
    begin
        p3_next  = P_W'($signed({pex_reg[51], pex_reg}) + $signed({pey_reg[51], pey_reg}));
        q3_next  = {2'b00, exsq_reg} + {2'b00, eysq_reg} - (Q_W'(1) << 34);
        s3_next  = {2'b00, dxsq_reg} + {2'b00, dysq_reg};
        qz3_next = (q3_next == '0);
    end

    // stage 4 logic: split products
    always_comb
    begin
        pm_full  = p3_reg[P_W-1] ? P_W'(-p3_reg) : p3_reg;
        pm       = pm_full[51:0];
        qm_full  = q3_reg[Q_W-1] ? Q_W'(-q3_reg) : q3_reg;
        qm       = qm_full[QM_W-1:0];
        phh_next = pm[51:26] * pm[51:26];
        phl_next = pm[51:26] * pm[25:0];
        pll_next = pm[25:0] * pm[25:0];
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                qs_pp_next[i][j] = qm[19*i +: 19] * s3_reg[22*j +: 22];
            end
        end
    end

    // stage 5 logic: recombine
    always_comb
    begin
        p2_next = (K_W'(phh_reg) << 52) + (K_W'(phl_reg) << 27) + K_W'(pll_reg);
        qs_next = '0;
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                qs_next = qs_next + (K_W'(qs_pp_reg[i][j]) << (19 * i + 22 * j));
            end
        end
    end

    // stage 6 logic: K and early status
    always_comb
    begin
        q_pos         = ~q5_reg[Q_W-1] & ~qz5_reg;
        diff          = {1'b0, p2_reg} - {1'b0, qs_reg};
        out_next.kr   = q_pos ? diff[K_W-1:0] : (p2_reg + qs_reg);
        out_next.rem  = '0;
        out_next.root = '0;
        out_next.p    = p5_reg;
        out_next.q    = q5_reg;
        priority if (qz5_reg)
            out_next.st = ST_ZERO_DEN;
        else if (q_pos && diff[K_W])
            out_next.st = ST_NEG_DISC;
        else
            out_next.st = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            ex_reg <= ex_next;
            ey_reg <= ey_next;
        end
        if (ld[1])
        begin
            pex_reg  <= pex_next;
            pey_reg  <= pey_next;
            exsq_reg <= exsq_next;
            eysq_reg <= eysq_next;
            dxsq_reg <= dxsq_next;
            dysq_reg <= dysq_next;
        end
        if (ld[2])
        begin
            p3_reg  <= p3_next;
            q3_reg  <= q3_next;
            s3_reg  <= s3_next;
            qz3_reg <= qz3_next;
        end
        if (ld[3])
        begin
            phh_reg   <= phh_next;
            phl_reg   <= phl_next;
            pll_reg   <= pll_next;
            qs_pp_reg <= qs_pp_next;
            p4_reg    <= p3_reg;
            q4_reg    <= q3_reg;
            qz4_reg   <= qz3_reg;
        end
        if (ld[4])
        begin
            p2_reg  <= p2_next;
            qs_reg  <= qs_next;
            p5_reg  <= p4_reg;
            q5_reg  <= q4_reg;
            qz5_reg <= qz4_reg;
        end
        if (ld[5])
        begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/erbr_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erbr_sqrt_cell
// One root bit per cell: restoring digit step on two radicand bits.
// ----------------------------------------------------------------------------
module erbr_sqrt_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            up_valid,
    output logic                 up_ready,
    input  wire erbr_pkg::sqrt_t up,
    output logic                 dn_valid,
    input  wire logic            dn_ready,
    output erbr_pkg::sqrt_t      dn
);
    import erbr_pkg::*;

    localparam int SH_W = REM_W + 2;

    logic        valid_reg;
    sqrt_t       data_reg, data_next;
    logic [SH_W-1:0] rem_sh, trial, diff;
    logic        take;

    // trial subtract of (4*root + 1)
    always_comb
    begin
        rem_sh    = {up.rem, up.kr[K_W-1 -: 2]};
        trial     = {2'b00, up.root, 2'b01};
        diff      = rem_sh - trial;
        take      = (rem_sh >= trial);
        data_next = up;
        data_next.kr   = {up.kr[K_W-3:0], 2'b00};
        data_next.rem  = take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        data_next.root = {up.root[ROOT_W-2:0], take};
    end

    assign up_ready = ~valid_reg | dn_ready;
    assign dn_valid = valid_reg;
    assign dn       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/erbr_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// erbr_div_cell
// One quotient bit per cell: restoring compare and subtract against |Q|.
// ----------------------------------------------------------------------------
module erbr_div_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire erbr_pkg::div_t up,
    output logic                dn_valid,
    input  wire logic           dn_ready,
    output erbr_pkg::div_t      dn
);
    import erbr_pkg::*;

    logic            valid_reg;
    div_t            data_reg, data_next;
    logic [QM_W:0]   rem_sh, diff;
    logic            take;

    always_comb
    begin
        rem_sh    = {up.rem, up.num[QUO_W-1]};
        diff      = rem_sh - {1'b0, up.qm};
        take      = (rem_sh >= {1'b0, up.qm});
        data_next = up;
        data_next.rem = take ? diff[QM_W-1:0] : rem_sh[QM_W-1:0];
        data_next.num = {up.num[QUO_W-2:0], 1'b0};
        data_next.quo = {up.quo[QUO_W-2:0], take};
    end

    assign up_ready = ~valid_reg | dn_ready;
    assign dn_valid = valid_reg;
    assign dn       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the equal radius biarc radius block.
// ----------------------------------------------------------------------------
// Geometry queries are queued by a stimulus process and offered by a driver
// with random gaps. A monitor with random back-pressure collects results and
// compares them with an exact wide-integer prediction of each radius.
// ----------------------------------------------------------------------------
module tb;
    import erbr_pkg::*;

    localparam int LATENCY = 93;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    query_valid = 1'b0;
    logic    query_ready;
    query_t  query = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    query_t  pending_q[$];
    result_t radius_exp_q[$];
    int      n_err = 0;
    int      n_seen = 0;
    int      n_status[4] = '{0, 0, 0, 0};
    bit      stim_done = 1'b0;
    bit      hold_off = 1'b0;

    equal_radius_biarc_radius u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_ready  (query_ready),
        .query        (query),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #10 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // exact radius prediction in wide integers
    function automatic result_t predict_radius(query_t qi);
        result_t     res;
        logic signed [63:0]  dx, dy, ex, ey, p, q, n;
        logic signed [127:0] k, p2, qs, s2;
        logic [127:0]        root, c, nm, qm, q0, rem, m;
        bit                  neg;
        dx = $signed(qi.start_x) - $signed(qi.end_x);
        dy = $signed(qi.start_y) - $signed(qi.end_y);
        ex = $signed(qi.dir_a_x) - $signed(qi.dir_b_x);
        ey = $signed(qi.dir_a_y) - $signed(qi.dir_b_y);
        p = dx * ex + dy * ey;
        q = ex * ex + ey * ey - (64'sd1 <<< 34);
        res = '0;
        if (q == 0)
        begin
            res.status = ST_ZERO_DEN;
            return res;
        end
        s2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
        p2 = 128'(p) * 128'(p);
        qs = 128'(q) * s2;
        k = p2 - qs;
        if (k < 0)
        begin
            res.status = ST_NEG_DISC;
            return res;
        end
        root = 0;
        for (int b = 52; b >= 0; b--)
        begin
            c = root | (128'd1 << b);
            if (c * c <= k)
                root = c;
        end
        n = p - 64'(root);
        neg = (n < 0) != (q < 0);
        nm = (n < 0) ? 128'(-n) : 128'(n);
        qm = (q < 0) ? 128'(-q) : 128'(q);
        q0 = nm / qm;
        rem = nm % qm;
        if (q0 > (128'd1 << 15))
            m = 128'd1 << 32;
        else
            m = (q0 << 16) + ((rem << 16) / qm);
        if (!neg && m > 128'h7FFF_FFFF)
        begin
            res.radius = 32'h7FFF_FFFF;
            res.status = ST_SAT;
        end
        else if (neg && m > 128'h8000_0000)
        begin
            res.radius = 32'h8000_0000;
            res.status = ST_SAT;
        end
        else
        begin
            res.radius = neg ? 32'(-m) : 32'(m);
            res.status = ST_OK;
        end
        return res;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        n_err++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    // direction component: random within unit magnitude, exactly +1.0 or -1.0, or raw random
    function automatic logic [17:0] rand_dir();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 18'(int'($urandom_range(0, 65536)) * (($urandom_range(0, 1) != 0) ? -1 : 1));
        else if (r < 5)
            return ($urandom_range(0, 1) != 0) ? 18'h10000 : 18'h30000;
        else
            return 18'($urandom);
    endfunction

    function automatic logic [31:0] rand_pos();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 32'(int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        else if (r < 8)
            return 32'(int'($urandom_range(0, 32'h0000_FFFF)) - 32'sh0000_8000);
        else
            return $urandom;
    endfunction

    task automatic add_query(input logic [31:0] sx, sy, ex, ey,
                             input logic [17:0] ax, ay, bx, by);
        query_t qi;
        qi.start_x = sx; qi.start_y = sy; qi.end_x = ex; qi.end_y = ey;
        qi.dir_a_x = ax; qi.dir_a_y = ay; qi.dir_b_x = bx; qi.dir_b_y = by;
        pending_q.push_back(qi);
    endtask

    // stimulus
    initial
    begin
        query_t       qi;
        logic [287:0] raw_bits;
        // zero denominator: opposite unit normals make ex^2+ey^2 = 4
        add_query(32'h0001_0000, 0, 0, 0, 18'h10000, 0, 18'h30000, 0);
        add_query(32'h0005_0000, 32'h0003_0000, 0, 0, 0, 18'h10000, 0, 18'h30000);
        // coincident points and equal normals
        add_query(0, 0, 0, 0, 18'h10000, 0, 18'h10000, 0);
        add_query(32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 0, 0, 0, 0);
        // typical
        add_query(32'h0002_0000, 0, 0, 0, 0, 18'h10000, 0, 18'h30000);
        add_query(32'h0002_0000, 0, 0, 0, 0, 18'h10000, 0, 18'h10000);
        // extreme positions and directions
        add_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  18'h1FFFF, 18'h1FFFF, 18'h20000, 18'h20000);
        add_query(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  18'h20000, 18'h20000, 18'h1FFFF, 18'h1FFFF);
        add_query(32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 0, 0, 0, 0);
        add_query(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 18'h20000, 0, 0, 18'h1FFFF);
        add_query(32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 18'h3FFFF, 18'h00001, 0, 0);
        // large ex/ey with tiny and large separations (saturation / negative discriminant)
        add_query(32'h0000_0001, 0, 0, 0, 18'h1FFFF, 0, 18'h20000, 0);
        add_query(32'h7000_0000, 0, 0, 0, 18'h10001, 0, 18'h30000, 0);
        add_query(32'h7000_0000, 32'h7000_0000, 32'h9000_0000, 0, 18'h0FFFF, 0, 18'h30000, 0);
        repeat (1750)
        begin
            if ($urandom_range(0, 9) < 8)
                add_query(rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                          rand_dir(), rand_dir(), rand_dir(), rand_dir());
            else
            begin
                raw_bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom};
                qi = raw_bits[199:0];
                pending_q.push_back(qi);
            end
        end
        stim_done = 1'b1;
    end

    // reset
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver: sample the handshake on the rising edge, update at the falling edge
    int  drv_gap = 0;
    bit  q_acc = 1'b0;
    always @(posedge clk)
    begin
        q_acc <= query_valid && query_ready && rst_n;
        if (query_valid && query_ready && rst_n)
            radius_exp_q.push_back(predict_radius(query));
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (q_acc)
                drv_gap = gap_len();
            if (!query_valid || q_acc)
            begin
                if (drv_gap > 0)
                begin
                    drv_gap--;
                    query_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    query <= pending_q.pop_front();
                    query_valid <= 1'b1;
                end
                else
                    query_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure, with one long hold-off
    int rcv_gap = 0;
    int hold_cnt = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_off && hold_cnt == 0 && radius_exp_q.size() > 40)
            begin
                hold_off = 1'b1;
                hold_cnt = 300;
            end
            if (hold_off)
            begin
                result_ready <= 1'b0;
                hold_cnt--;
                if (hold_cnt == 0)
                    hold_off = 1'b0;
                hold_cnt = hold_off ? hold_cnt : -1;
            end
            else if (rcv_gap > 0)
            begin
                result_ready <= 1'b0;
                rcv_gap--;
            end
            else
            begin
                result_ready <= 1'b1;
                if ($urandom_range(0, 9) < 3)
                    rcv_gap = gap_len();
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (radius_exp_q.size() == 0)
            begin
                n_err++;
                $display("unexpected result %h at %0t", result, $realtime);
            end
            else
            begin
                want = radius_exp_q.pop_front();
                n_seen++;
                n_status[want.status]++;
                if (result.radius !== want.radius)
                    report("radius", result.radius, want.radius);
                if (result.status !== want.status)
                    report("status", 32'(result.status), 32'(want.status));
            end
        end
    end

    // end of run
    initial
    begin
        wait (stim_done && rst_n);
        wait (pending_q.size() == 0 && !query_valid);
        wait (radius_exp_q.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        $display("checked %0d radii: %0d ok, %0d negative discriminant,", n_seen,
                 n_status[0], n_status[1]);
        $display("%0d zero denominator, %0d saturated; long output stall included",
                 n_status[2], n_status[3]);
        if (n_err == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("timeout");
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/erbr_pkg.sv
hdl/erbr_front.sv
hdl/erbr_sqrt_cell.sv
hdl/erbr_div_cell.sv
hdl/equal_radius_biarc_radius.sv
dv/tb.sv
